[hdl/cau_pkg.sv]
// Package for the complex arithmetic unit: opcodes, payload structs and
// pipeline sideband types. No dependencies.
package cau_pkg;

    localparam int unsigned DATA_W       = 16;
    localparam int unsigned FRAC_BITS_DF = 8;
    localparam int unsigned QUO_BITS     = 17;
    localparam int unsigned PROD_W       = 2 * DATA_W;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NE  = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic                     cmp_true;
        logic                     overflow;
        logic                     div_by_zero;
    } res_t;

    // travels beside the divider lanes
    typedef struct packed {
        res_t res;
        logic is_div;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
    } side_t;

endpackage

[hdl/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: front end, divider pipeline, result
// stage and output register. Depends on cau_pkg, cau_front, cau_div.
//
//   channel   ports                        payload
//   request   s_valid s_ready s_data       req_t
//   result    m_valid m_ready m_data       res_t
//
// One request per cycle unless the output register is full and not taken;
// every request passes through the 17-stage divider.
// Synchronous active-low reset clears all valid bits.
// The whole pipeline holds while the output register is full and not taken.
module complex_arithmetic_unit #(
    parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cau_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cau_pkg::res_t  m_data
);
    import cau_pkg::*;

    localparam int unsigned NUM_W = PROD_W + FRAC_BITS;

    logic                en;
    logic                f_valid, d_valid;
    side_t               f_side, d_side;
    logic [NUM_W-1:0]    num_re, num_im;
    logic [PROD_W-1:0]   den;
    logic [QUO_BITS-1:0] quo_re, quo_im;
    logic                m_valid_reg;
    res_t                m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    cau_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_data(s_data),
        .out_valid(f_valid), .out_side(f_side),
        .num_re(num_re), .num_im(num_im), .den(den)
    );

    cau_div #(.NUM_W(NUM_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(f_valid), .in_side(f_side),
        .num_re(num_re), .num_im(num_im), .den(den),
        .out_valid(d_valid), .out_side(d_side),
        .quo_re(quo_re), .quo_im(quo_im)
    );

    function automatic logic signed [DATA_W-1:0] fix_quo(input logic [QUO_BITS-1:0] q,
                                                         input logic neg, input logic big,
                                                         output logic ovf);
        logic [QUO_BITS-1:0] lim;
        lim = neg ? QUO_BITS'(32768) : QUO_BITS'(32767);
        ovf = big || (q > lim);
        if (ovf) begin
            return neg ? DATA_W'(16'h8000) : DATA_W'(16'h7fff);
        end
        return neg ? DATA_W'(-q) : DATA_W'(q);
    endfunction

    always_comb begin
        logic o_re, o_im;
        o_re = 1'b0;
        o_im = 1'b0;
        m_data_next = d_side.res;
        if (d_side.is_div) begin
            m_data_next.res_re   = fix_quo(quo_re, d_side.neg_re, d_side.big_re, o_re);
            m_data_next.res_im   = fix_quo(quo_im, d_side.neg_im, d_side.big_im, o_im);
            m_data_next.overflow = o_re | o_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/cau_front.sv]
// Front end: add, subtract and compare results, products, sums, multiply result,
// divide operand preparation. Three register stages. Depends on cau_pkg.
module cau_front #(
    parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DF,
    parameter int unsigned NUM_W     = cau_pkg::PROD_W + FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  cau_pkg::req_t               in_data,
    output logic                        out_valid,
    output cau_pkg::side_t              out_side,
    output logic [NUM_W-1:0]            num_re,
    output logic [NUM_W-1:0]            num_im,
    output logic [cau_pkg::PROD_W-1:0]  den
);
    import cau_pkg::*;

    localparam int unsigned SUM_W = PROD_W + 1;
    localparam int unsigned CMP_W = NUM_W + QUO_BITS + 1;

    // stage 1
    logic                     v1_reg;
    op_t                      op1_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, d_r_reg, d_i_reg;
    res_t                     simple1_reg, simple1_next;
    // stage 2
    logic                     v2_reg;
    op_t                      op2_reg;
    logic signed [SUM_W-1:0]  m_re_reg, m_im_reg, n_re_reg, n_im_reg;
    logic [PROD_W-1:0]        den2_reg;
    res_t                     simple2_reg;
    // stage 3
    logic                     v3_reg;
    side_t                    side3_reg, side3_next;
    logic [NUM_W-1:0]         num_re_reg, num_im_reg, num_re_next, num_im_next;
    logic [PROD_W-1:0]        den3_reg;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] x,
                                                       output logic ovf);
        logic signed [SUM_W-1:0] hi, lo;
        hi = SUM_W'(signed'(17'sd32767));
        lo = SUM_W'(signed'(-17'sd32768));
        ovf = 1'b0;
        if (x > hi) begin
            ovf = 1'b1;
            return DATA_W'(hi);
        end else if (x < lo) begin
            ovf = 1'b1;
            return DATA_W'(lo);
        end
        return DATA_W'(x);
    endfunction

    function automatic logic signed [SUM_W-1:0] trunc_shift(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] bias;
        bias = x[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0;
        return (x + bias) >>> FRAC_BITS;
    endfunction

    always_comb begin
        logic signed [SUM_W-1:0] s_re, s_im;
        logic o_re, o_im, eq;
        simple1_next = '0;
        s_re = '0;
        s_im = '0;
        o_re = 1'b0;
        o_im = 1'b0;
        eq = (in_data.a_re == in_data.b_re) && (in_data.a_im == in_data.b_im);
        case (op_t'(in_data.req_type))
            OP_ADD: begin
                s_re = SUM_W'(in_data.a_re) + SUM_W'(in_data.b_re);
                s_im = SUM_W'(in_data.a_im) + SUM_W'(in_data.b_im);
                simple1_next.res_re = sat16(s_re, o_re);
                simple1_next.res_im = sat16(s_im, o_im);
                simple1_next.overflow = o_re | o_im;
            end
            OP_SUB: begin
                s_re = SUM_W'(in_data.a_re) - SUM_W'(in_data.b_re);
                s_im = SUM_W'(in_data.a_im) - SUM_W'(in_data.b_im);
                simple1_next.res_re = sat16(s_re, o_re);
                simple1_next.res_im = sat16(s_im, o_im);
                simple1_next.overflow = o_re | o_im;
            end
            OP_EQ:   simple1_next.cmp_true = eq;
            OP_NE:   simple1_next.cmp_true = !eq;
            default: simple1_next = '0;
        endcase
    end

    always_comb begin
        logic signed [SUM_W-1:0] t_re, t_im;
        logic [SUM_W-1:0]        a_re, a_im;
        logic [CMP_W-1:0]        lim;
        logic o_re, o_im;
        side3_next = '0;
        o_re = 1'b0;
        o_im = 1'b0;
        t_re = trunc_shift(m_re_reg);
        t_im = trunc_shift(m_im_reg);
        a_re = n_re_reg[SUM_W-1] ? SUM_W'(-n_re_reg) : SUM_W'(n_re_reg);
        a_im = n_im_reg[SUM_W-1] ? SUM_W'(-n_im_reg) : SUM_W'(n_im_reg);
        num_re_next = NUM_W'(a_re) << FRAC_BITS;
        num_im_next = NUM_W'(a_im) << FRAC_BITS;
        lim = CMP_W'(den2_reg) << QUO_BITS;
        case (op2_reg)
            OP_MUL: begin
                side3_next.res.res_re = sat16(t_re, o_re);
                side3_next.res.res_im = sat16(t_im, o_im);
                side3_next.res.overflow = o_re | o_im;
            end
            OP_DIV: begin
                if (den2_reg == '0) begin
                    side3_next.res.div_by_zero = 1'b1;
                end else begin
                    side3_next.is_div = 1'b1;
                    side3_next.neg_re = n_re_reg[SUM_W-1];
                    side3_next.neg_im = n_im_reg[SUM_W-1];
                    side3_next.big_re = CMP_W'(num_re_next) >= lim;
                    side3_next.big_im = CMP_W'(num_im_next) >= lim;
                end
            end
            default: side3_next.res = simple2_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg     <= op_t'(in_data.req_type);
            p_rr_reg    <= in_data.a_re * in_data.b_re;
            p_ii_reg    <= in_data.a_im * in_data.b_im;
            p_ri_reg    <= in_data.a_re * in_data.b_im;
            p_ir_reg    <= in_data.a_im * in_data.b_re;
            d_r_reg     <= in_data.b_re * in_data.b_re;
            d_i_reg     <= in_data.b_im * in_data.b_im;
            simple1_reg <= simple1_next;

            op2_reg     <= op1_reg;
            m_re_reg    <= SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg);
            m_im_reg    <= SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg);
            n_re_reg    <= SUM_W'(p_rr_reg) + SUM_W'(p_ii_reg);
            n_im_reg    <= SUM_W'(p_ir_reg) - SUM_W'(p_ri_reg);
            den2_reg    <= PROD_W'(d_r_reg) + PROD_W'(d_i_reg);
            simple2_reg <= simple1_reg;

            side3_reg   <= side3_next;
            num_re_reg  <= num_re_next;
            num_im_reg  <= num_im_next;
            den3_reg    <= den2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_side  = side3_reg;
    assign num_re    = num_re_reg;
    assign num_im    = num_im_reg;
    assign den       = den3_reg;

endmodule

[hdl/cau_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one divisor, with sideband carried alongside. Depends on cau_pkg.
module cau_div #(
    parameter int unsigned NUM_W = cau_pkg::PROD_W + cau_pkg::FRAC_BITS_DF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  cau_pkg::side_t                in_side,
    input  logic [NUM_W-1:0]              num_re,
    input  logic [NUM_W-1:0]              num_im,
    input  logic [cau_pkg::PROD_W-1:0]    den,
    output logic                          out_valid,
    output cau_pkg::side_t                out_side,
    output logic [cau_pkg::QUO_BITS-1:0]  quo_re,
    output logic [cau_pkg::QUO_BITS-1:0]  quo_im
);
    import cau_pkg::*;

    localparam int unsigned CMP_W = NUM_W + QUO_BITS + 1;

    logic                v_reg    [1:QUO_BITS];
    side_t               side_reg [1:QUO_BITS];
    logic [NUM_W-1:0]    rre_reg  [1:QUO_BITS];
    logic [NUM_W-1:0]    rim_reg  [1:QUO_BITS];
    logic [PROD_W-1:0]   den_reg  [1:QUO_BITS];
    logic [QUO_BITS-1:0] qre_reg  [1:QUO_BITS];
    logic [QUO_BITS-1:0] qim_reg  [1:QUO_BITS];

    for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
        localparam int unsigned K = QUO_BITS - 1 - i;
        logic                v_cur;
        side_t               side_cur;
        logic [NUM_W-1:0]    rre_cur, rim_cur;
        logic [PROD_W-1:0]   den_cur;
        logic [QUO_BITS-1:0] qre_cur, qim_cur;
        logic [CMP_W-1:0]    trial;
        logic                ge_re, ge_im;
        logic [NUM_W-1:0]    rre_next, rim_next;
        logic [QUO_BITS-1:0] qre_next, qim_next;

        if (i == 0) begin : g_first
            assign v_cur    = in_valid;
            assign side_cur = in_side;
            assign rre_cur  = num_re;
            assign rim_cur  = num_im;
            assign den_cur  = den;
            assign qre_cur  = '0;
            assign qim_cur  = '0;
        end else begin : g_rest
            assign v_cur    = v_reg[i];
            assign side_cur = side_reg[i];
            assign rre_cur  = rre_reg[i];
            assign rim_cur  = rim_reg[i];
            assign den_cur  = den_reg[i];
            assign qre_cur  = qre_reg[i];
            assign qim_cur  = qim_reg[i];
        end

        always_comb begin
            trial    = CMP_W'(den_cur) << K;
            ge_re    = CMP_W'(rre_cur) >= trial;
            ge_im    = CMP_W'(rim_cur) >= trial;
            rre_next = ge_re ? NUM_W'(CMP_W'(rre_cur) - trial) : rre_cur;
            rim_next = ge_im ? NUM_W'(CMP_W'(rim_cur) - trial) : rim_cur;
            qre_next = qre_cur;
            qim_next = qim_cur;
            qre_next[K] = ge_re;
            qim_next[K] = ge_im;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i+1] <= side_cur;
                den_reg[i+1]  <= den_cur;
                rre_reg[i+1]  <= rre_next;
                rim_reg[i+1]  <= rim_next;
                qre_reg[i+1]  <= qre_next;
                qim_reg[i+1]  <= qim_next;
            end
        end
    end

    assign out_valid = v_reg[QUO_BITS];
    assign out_side  = side_reg[QUO_BITS];
    assign quo_re    = qre_reg[QUO_BITS];
    assign quo_im    = qim_reg[QUO_BITS];

endmodule
